// ===== hw/rtl/aec_pkg.sv =====
// Shared types, constants and codes for the ANSI escape cursor engine.
package aec_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int COL_BITS = 12;
  localparam int ROW_BITS = 16;

  localparam int STACK_CNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam int STACK_IDX_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Fixed field widths of the item interface.
  localparam int CH_W = 16;
  localparam int ROW_W = 16;
  localparam int COL_W = 12;
  localparam int PARAM_W = 16;
  localparam int WRAP_W = 12;
  localparam int WLIM_W = 13;
  localparam int HLIM_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;

  // Coordinate width wide enough to hold a position plus a parameter.
  localparam int POS_BASE = (ROW_BITS > COL_BITS) ?
                            ((ROW_BITS > PARAM_W) ? ROW_BITS : PARAM_W) :
                            ((COL_BITS > PARAM_W) ? COL_BITS : PARAM_W);
  localparam int POS_W = POS_BASE + 1;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  localparam logic [WRAP_W-1:0] DEFAULT_WRAP = WRAP_W'(80);
  localparam logic [WLIM_W-1:0] RESET_WLIM = WLIM_W'(4096);
  localparam logic [HLIM_W-1:0] RESET_HLIM = HLIM_W'(65535);
  localparam logic [PARAM_W-1:0] PARAM_MAX = PARAM_W'(65535);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT = 2'd2;

  // Character codes.
  localparam logic [CH_W-1:0] CH_ESC = 16'h2190;
  localparam logic [CH_W-1:0] CH_CR = 16'h000D;
  localparam logic [CH_W-1:0] CH_LF = 16'h000A;
  localparam logic [CH_W-1:0] CH_SEMI = 16'h003B;
  localparam logic [CH_W-1:0] CH_QUEST = 16'h003F;
  localparam logic [CH_W-1:0] CH_BRACKET = 16'h005B;
  localparam logic [CH_W-1:0] CH_ZERO = 16'h0030;
  localparam logic [CH_W-1:0] CH_NINE = 16'h0039;
  localparam logic [CH_W-1:0] CH_UPPER_A = 16'h0041;
  localparam logic [CH_W-1:0] CH_UPPER_Z = 16'h005A;
  localparam logic [CH_W-1:0] CH_LOWER_A = 16'h0061;
  localparam logic [CH_W-1:0] CH_LOWER_Z = 16'h007A;

  // Command letters.
  localparam logic [CH_W-1:0] CMD_UP = 16'h0041;
  localparam logic [CH_W-1:0] CMD_DOWN = 16'h0042;
  localparam logic [CH_W-1:0] CMD_RIGHT = 16'h0043;
  localparam logic [CH_W-1:0] CMD_LEFT = 16'h0044;
  localparam logic [CH_W-1:0] CMD_NEXT_LINE = 16'h0045;
  localparam logic [CH_W-1:0] CMD_PREV_LINE = 16'h0046;
  localparam logic [CH_W-1:0] CMD_COLUMN = 16'h0047;
  localparam logic [CH_W-1:0] CMD_POS = 16'h0048;
  localparam logic [CH_W-1:0] CMD_ERASE = 16'h004A;
  localparam logic [CH_W-1:0] CMD_POS_ALT = 16'h0066;
  localparam logic [CH_W-1:0] CMD_SAVE = 16'h0073;
  localparam logic [CH_W-1:0] CMD_RESTORE = 16'h0075;

  // Parameter phases.
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_FIRST_DONE = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  typedef enum logic [2:0] {
    MODE_TEXT    = 3'b001,
    MODE_BRACKET = 3'b010,
    MODE_DATA    = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CELL  = 2'd0,
    KIND_OK    = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    logic [WRAP_W-1:0] wrap_width;
    logic [WLIM_W-1:0] width_limit;
    logic [HLIM_W-1:0] height_limit;
  } cfg_t;

  typedef struct packed {
    kind_t            kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [CH_W-1:0]  glyph;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== hw/rtl/ansi_escape_cursor_engine_top.sv =====
// An item taken is held in the input register, decoded by the core, then queued as results.
// Throughput: one item per cycle while the result queue has room for two results.
// The sustained rate is set by the output side: one result per cycle while out_stall is low.
// Reset (rst, synchronous, active high) clears parser, cursor, stack count and queue,
// and sets wrap_width 80, width_limit 4096, height_limit 65535; stack entries are not cleared.
module ansi_escape_cursor_engine_top
  import aec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CH_W-1:0]       ch,
  input  logic                  end_of_text,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            kind,
  output logic [ROW_W-1:0]      row,
  output logic [COL_W-1:0]      col,
  output logic [CH_W-1:0]       glyph,
  output logic                  last_of_run,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t            cfg;
  logic            in_q_valid;
  logic [CH_W-1:0] ch_q;
  logic            eot_q;
  logic            room, advance;
  push_t           push;
  result_t         head;

  assign advance = in_q_valid && room;
  assign in_stall = in_q_valid && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap_width <= DEFAULT_WRAP;
      cfg.width_limit <= RESET_WLIM;
      cfg.height_limit <= RESET_HLIM;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_WRAP_WIDTH:   cfg.wrap_width <= cfg_data[WRAP_W-1:0];
        CFG_WIDTH_LIMIT:  cfg.width_limit <= cfg_data[WLIM_W-1:0];
        CFG_HEIGHT_LIMIT: cfg.height_limit <= cfg_data[HLIM_W-1:0];
        default: begin
          cfg.wrap_width <= cfg.wrap_width;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ch_q <= ch;
      eot_q <= end_of_text;
    end
  end

  aec_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ch   (ch_q),
    .eot  (eot_q),
    .cfg  (cfg),
    .push (push)
  );

  aec_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (!out_stall),
    .room       (room),
    .head_valid (out_valid),
    .head       (head)
  );

  assign kind = head.kind;
  assign row = head.row;
  assign col = head.col;
  assign glyph = head.glyph;
  assign last_of_run = head.last_of_run;

endmodule

// ===== hw/rtl/aec_core.sv =====
// Parser, cursor update and save stack: one item per cycle while step is high, up to two results.
module aec_core
  import aec_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [CH_W-1:0] ch,
  input  logic            eot,
  input  cfg_t            cfg,
  output push_t           push
);

  mode_t                     mode, mode_next;
  logic [PARAM_W-1:0]        first_param, first_param_next;
  logic [PARAM_W-1:0]        second_param, second_param_next;
  logic [1:0]                param_phase, param_phase_next;
  logic [COL_BITS-1:0]       cursor_col, cursor_col_next;
  logic [ROW_BITS-1:0]       cursor_row, cursor_row_next;
  logic [STACK_CNT_BITS-1:0] stack_count, stack_count_next;
  logic                      failed, failed_next;
  logic                      seen_any, seen_any_next;

  logic [COL_BITS-1:0]       saved_cols [STACK_DEPTH];
  logic [ROW_BITS-1:0]       saved_rows [STACK_DEPTH];
  logic                      stack_push;
  logic [STACK_IDX_BITS-1:0] push_idx, pop_idx;

  logic [POS_W-1:0]   cur_r, cur_c, n_w, m_w, col_plus, tgt_r, tgt_c;
  logic [PARAM_W-1:0] n_val, m_val, acc_in, acc_sat;
  logic [19:0]        acc_prod;
  logic [3:0]         digit;
  logic [WRAP_W-1:0]  wrap;
  logic               is_digit, is_letter, do_move, fail_now, emit_cell;
  logic               cur_ok, tgt_ok, fail_final, seen_final;
  result_t            cell_res, status_res;

  function automatic logic pos_ok(input logic [POS_W-1:0] r, input logic [POS_W-1:0] c,
                                  input cfg_t k);
    logic c_in, r_in;
    c_in = (c < POS_W'(k.width_limit)) && ((c >> COL_BITS) == '0);
    r_in = (r < POS_W'(k.height_limit)) && ((r >> ROW_BITS) == '0);
    return c_in && r_in;
  endfunction

  assign cur_r = POS_W'(cursor_row);
  assign cur_c = POS_W'(cursor_col);
  assign n_val = (first_param == '0) ? PARAM_W'(1) : first_param;
  assign m_val = (second_param == '0) ? PARAM_W'(1) : second_param;
  assign n_w = POS_W'(n_val);
  assign m_w = POS_W'(m_val);
  assign col_plus = cur_c + POS_W'(1);
  assign wrap = (cfg.wrap_width == '0) ? DEFAULT_WRAP : cfg.wrap_width;
  assign cur_ok = pos_ok(cur_r, cur_c, cfg);

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_letter = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
                     ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));
  assign digit = 4'(ch - CH_ZERO);

  // Decimal accumulate as p*8 + p*2 + d, saturating at the parameter maximum.
  assign acc_in = (param_phase == PH_SECOND) ? second_param : first_param;
  assign acc_prod = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + 20'(digit);
  assign acc_sat = (acc_prod > 20'(PARAM_MAX)) ? PARAM_MAX : acc_prod[PARAM_W-1:0];

  assign push_idx = stack_count[STACK_IDX_BITS-1:0];
  assign pop_idx = STACK_IDX_BITS'(stack_count - 1'b1);

  always_comb begin
    mode_next = mode;
    first_param_next = first_param;
    second_param_next = second_param;
    param_phase_next = param_phase;
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    stack_count_next = stack_count;
    seen_any_next = seen_any;
    stack_push = 1'b0;
    do_move = 1'b0;
    tgt_r = '0;
    tgt_c = '0;
    fail_now = 1'b0;
    emit_cell = 1'b0;

    if (!failed) begin
      unique case (mode)
        MODE_TEXT: begin
          if (ch == CH_ESC) begin
            mode_next = MODE_BRACKET;
            first_param_next = '0;
            second_param_next = '0;
            param_phase_next = PH_FIRST;
          end else begin
            seen_any_next = 1'b1;
            if (ch == CH_CR) begin
              do_move = 1'b0;
            end else if (ch == CH_LF) begin
              do_move = 1'b1;
              tgt_r = cur_r + POS_W'(1);
            end else if (!cur_ok) begin
              fail_now = 1'b1;
            end else begin
              // The cell is written at the cursor, then the cursor advances.
              emit_cell = 1'b1;
              do_move = 1'b1;
              if (col_plus >= POS_W'(wrap)) begin
                tgt_r = cur_r + POS_W'(1);
              end else begin
                tgt_r = cur_r;
                tgt_c = col_plus;
              end
            end
          end
        end
        MODE_BRACKET: begin
          if (ch == CH_BRACKET) begin
            mode_next = MODE_DATA;
          end else begin
            fail_now = 1'b1;
          end
        end
        MODE_DATA: begin
          if (is_digit) begin
            if (param_phase == PH_FIRST) begin
              first_param_next = acc_sat;
            end else if (param_phase == PH_SECOND) begin
              second_param_next = acc_sat;
            end
          end else if (ch == CH_SEMI) begin
            param_phase_next = (param_phase == PH_FIRST || param_phase == PH_FIRST_DONE) ?
                               PH_SECOND : PH_DONE;
          end else if (ch == CH_QUEST) begin
            if (param_phase == PH_FIRST) begin
              param_phase_next = PH_FIRST_DONE;
            end else if (param_phase == PH_SECOND) begin
              param_phase_next = PH_DONE;
            end
          end else if (is_letter) begin
            seen_any_next = 1'b1;
            mode_next = MODE_TEXT;
            case (ch) inside
              CMD_UP: begin
                if (n_w > cur_r) begin
                  fail_now = 1'b1;
                end else begin
                  do_move = 1'b1;
                  tgt_r = cur_r - n_w;
                  tgt_c = cur_c;
                end
              end
              CMD_DOWN: begin
                do_move = 1'b1;
                tgt_r = cur_r + n_w;
                tgt_c = cur_c;
              end
              CMD_RIGHT: begin
                do_move = 1'b1;
                tgt_r = cur_r;
                tgt_c = cur_c + n_w;
              end
              CMD_LEFT: begin
                if (n_w > cur_c) begin
                  fail_now = 1'b1;
                end else begin
                  do_move = 1'b1;
                  tgt_r = cur_r;
                  tgt_c = cur_c - n_w;
                end
              end
              CMD_NEXT_LINE: begin
                do_move = 1'b1;
                tgt_r = cur_r + n_w;
              end
              CMD_PREV_LINE: begin
                if (n_w > cur_r) begin
                  fail_now = 1'b1;
                end else begin
                  do_move = 1'b1;
                  tgt_r = cur_r - n_w;
                end
              end
              CMD_COLUMN: begin
                do_move = 1'b1;
                tgt_r = cur_r;
                tgt_c = n_w - POS_W'(1);
              end
              CMD_POS, CMD_POS_ALT: begin
                do_move = 1'b1;
                tgt_r = n_w - POS_W'(1);
                tgt_c = m_w - POS_W'(1);
              end
              CMD_ERASE: begin
                do_move = (first_param == PARAM_W'(2));
              end
              CMD_SAVE: begin
                if (stack_count < STACK_CNT_BITS'(STACK_DEPTH)) begin
                  stack_push = 1'b1;
                  stack_count_next = stack_count + 1'b1;
                end
              end
              CMD_RESTORE: begin
                if (stack_count != '0) begin
                  stack_count_next = stack_count - 1'b1;
                  do_move = 1'b1;
                  tgt_r = POS_W'(saved_rows[pop_idx]);
                  tgt_c = POS_W'(saved_cols[pop_idx]);
                end
              end
              default: begin
                do_move = 1'b0;
              end
            endcase
          end else begin
            fail_now = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_TEXT;
        end
      endcase
    end

    tgt_ok = pos_ok(tgt_r, tgt_c, cfg);
    if (do_move) begin
      if (tgt_ok) begin
        cursor_row_next = tgt_r[ROW_BITS-1:0];
        cursor_col_next = tgt_c[COL_BITS-1:0];
      end else begin
        fail_now = 1'b1;
      end
    end

    failed_next = failed | fail_now;
    // An unfinished sequence at the end of the text counts as an error.
    fail_final = failed_next | (mode_next != MODE_TEXT);
    // The status looks at the state as it stands before the end-of-text clear.
    seen_final = seen_any_next;

    if (eot) begin
      mode_next = MODE_TEXT;
      first_param_next = '0;
      second_param_next = '0;
      param_phase_next = PH_FIRST;
      cursor_col_next = '0;
      cursor_row_next = '0;
      stack_count_next = '0;
      failed_next = 1'b0;
      seen_any_next = 1'b0;
    end
  end

  always_comb begin
    cell_res.kind = KIND_CELL;
    cell_res.row = ROW_W'(cursor_row);
    cell_res.col = COL_W'(cursor_col);
    cell_res.glyph = ch;
    cell_res.last_of_run = !eot;

    status_res.kind = fail_final ? KIND_ERROR : (seen_final ? KIND_OK : KIND_EMPTY);
    status_res.row = '0;
    status_res.col = '0;
    status_res.glyph = '0;
    status_res.last_of_run = 1'b1;

    push.first = emit_cell ? cell_res : status_res;
    push.second = status_res;
    push.count = step ? (2'(emit_cell) + 2'(eot)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      first_param <= '0;
      second_param <= '0;
      param_phase <= PH_FIRST;
      cursor_col <= '0;
      cursor_row <= '0;
      stack_count <= '0;
      failed <= 1'b0;
      seen_any <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      first_param <= first_param_next;
      second_param <= second_param_next;
      param_phase <= param_phase_next;
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      stack_count <= stack_count_next;
      failed <= failed_next;
      seen_any <= seen_any_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && stack_push) begin
      saved_cols[push_idx] <= cursor_col;
      saved_rows[push_idx] <= cursor_row;
    end
  end

endmodule

// ===== hw/rtl/aec_out_queue.sv =====
// Result queue that takes up to two results per cycle and releases one per cycle while pop is high.
module aec_out_queue
  import aec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output logic    room,
  output logic    head_valid,
  output result_t head
);

  result_t                entries [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wr_ptr, rd_ptr, wr_ptr_plus1;
  logic [OQ_CNT_BITS-1:0] count, count_next;

  assign wr_ptr_plus1 = wr_ptr + 1'b1;
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];
  // Room means two results fit whatever the consumer does this cycle.
  assign room = (count <= OQ_CNT_BITS'(OQ_DEPTH - 2));
  assign count_next = count + OQ_CNT_BITS'(push.count) - OQ_CNT_BITS'(pop && head_valid);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_BITS'(push.count);
      if (pop && head_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule
